// ===== hdl/bq_pkg.sv =====
// ----------------------------------------------------------------------------
// bq_pkg: shared types and constants of the biquad filter
// register indexes, filter modes, datapath widths and the divider request
// ----------------------------------------------------------------------------
package bq_pkg;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_K_TAN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_FACTOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd2;

  // register widths and reset values
  localparam int K_W    = 24;
  localparam int Q_W    = 16;
  localparam int MODE_W = 3;
  localparam logic [K_W-1:0]    K_RESET    = 24'd1048576;
  localparam logic [Q_W-1:0]    Q_RESET    = 16'd2896;
  localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_LP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AP = 3'd4;

  // rounded k squared, numerators and divisor, divider remainder
  localparam int KK_W    = 28;
  localparam int DIV_W   = 47;
  localparam int DIV_R_W = DIV_W + 3;

  // history words and accumulators
  localparam int HIST_W = 32;
  localparam int ACC_W  = 40;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/bq_if.sv =====
// ----------------------------------------------------------------------------
// bq_if: sample channels of the biquad filter
// valid/ready channels for the sample requests and the filtered results
// ----------------------------------------------------------------------------
interface bq_in_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  modport source (output valid, op, sample_in, input ready);
  modport sink   (input valid, op, sample_in, output ready);
endinterface

interface bq_out_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// ===== hdl/bq_mul.sv =====
// ----------------------------------------------------------------------------
// bq_mul: shared unsigned multiplier
// one registered product per cycle, used for derivation and filtering
// ----------------------------------------------------------------------------
module bq_mul #(
  parameter int A_W = 31,
  parameter int B_W = 32
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod
);

  // registered product
  always_ff @(posedge clk) begin
    prod <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

// ===== hdl/bq_div.sv =====
// ----------------------------------------------------------------------------
// bq_div: iterative coefficient divider
// floor(num * 2^FRAC_BITS / den), one quotient bit a cycle, saturated
// ----------------------------------------------------------------------------
module bq_div #(
  parameter int FRAC_BITS = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bq_pkg::div_req_t     req,
  output bq_pkg::div_stat_t    stat,
  output logic [FRAC_BITS+2:0] quot
);
  import bq_pkg::*;

  localparam int CW    = FRAC_BITS + 3;
  localparam int CNT_W = $clog2(CW + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CHECK = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  logic [1:0]         phase;
  logic [DIV_R_W-1:0] rem;
  logic [DIV_W-1:0]   den;
  logic [CNT_W-1:0]   cnt;
  logic               done;
  logic [DIV_R_W-1:0] den4;
  logic [DIV_R_W-1:0] den8;
  logic               ge;
  logic [DIV_R_W-1:0] rem_sub;

  assign den4    = {1'b0, den, 2'b00};
  assign den8    = {den, 3'b000};
  assign ge      = rem >= den4;
  assign rem_sub = ge ? rem - den4 : rem;

  // sequencer and restoring steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (req.start) begin
            rem   <= {3'b000, req.num};
            den   <= req.den;
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (den == '0) begin
            quot  <= '0;
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else if (rem >= den8) begin
            quot  <= {CW{1'b1}};
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else begin
            cnt   <= CNT_W'(CW);
            phase <= PH_RUN;
          end
        end
        PH_RUN: begin
          rem  <= {rem_sub[DIV_R_W-2:0], 1'b0};
          quot <= {quot[CW-2:0], ge};
          cnt  <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            done  <= 1'b1;
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign stat.busy = phase != PH_IDLE;
  assign stat.done = done;

endmodule

// ===== hdl/biquad_direct_form_two_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_direct_form_two_filter: second-order direct-form-II IIR filter
// coefficient derivation from k and q, shared multiplier, saturated output
// ----------------------------------------------------------------------------
// A filter request is taken when din.ready is high and passes through the
// sequencer steps M1 to M4, W, M5, D1, D2 and Y, where the result is
// registered once the output is free: the five products go one after
// another through the single multiplier, its rounding stage and the
// accumulator, and the b0 product has to wait for the saturated w. After
// reset and after every configuration write the coefficients are derived
// again by the bit-serial divider, three divisions in a row; din.ready
// stays low meanwhile. A clear request returns zero.
module biquad_direct_form_two_filter #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bq_pkg::CFG_W-1:0]    cfg_wdata,
  bq_in_if.sink                       din,
  bq_out_if.source                    dout
);
  import bq_pkg::*;

  localparam int CW     = COEF_FRAC_BITS + 3;
  localparam int MA_W   = (CW > KK_W) ? CW : KK_W;
  localparam int MB_W   = HIST_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int TERM_W = CW + 33 - COEF_FRAC_BITS;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_D_KK  = 5'd1;
  localparam logic [4:0] ST_D_KKR = 5'd2;
  localparam logic [4:0] ST_D_KKQ = 5'd3;
  localparam logic [4:0] ST_D_A1M = 5'd4;
  localparam logic [4:0] ST_D_SUM = 5'd5;
  localparam logic [4:0] ST_D_DA1 = 5'd6;
  localparam logic [4:0] ST_D_WA1 = 5'd7;
  localparam logic [4:0] ST_D_WA2 = 5'd8;
  localparam logic [4:0] ST_D_WB0 = 5'd9;
  localparam logic [4:0] ST_D_FIN = 5'd10;
  localparam logic [4:0] ST_S_M1  = 5'd11;
  localparam logic [4:0] ST_S_M2  = 5'd12;
  localparam logic [4:0] ST_S_M3  = 5'd13;
  localparam logic [4:0] ST_S_M4  = 5'd14;
  localparam logic [4:0] ST_S_W   = 5'd15;
  localparam logic [4:0] ST_S_M5  = 5'd16;
  localparam logic [4:0] ST_S_D1  = 5'd17;
  localparam logic [4:0] ST_S_D2  = 5'd18;
  localparam logic [4:0] ST_S_Y   = 5'd19;
  localparam logic [4:0] ST_S_CLR = 5'd20;

  localparam logic [CW-1:0] CMAX     = {CW{1'b1}};
  localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;
  localparam logic [KK_W-1:0] KK_ONE = KK_W'(1) << 20;

  // configuration registers and state
  logic [K_W-1:0]    k_tan;
  logic [Q_W-1:0]    q_factor;
  logic [MODE_W-1:0] filter_mode;
  logic              dirty;
  logic [4:0]        state;

  // derivation intermediates
  logic [KK_W-1:0]  kk;
  logic [DIV_W-1:0] kkq;
  logic [DIV_W-1:0] a1_half;
  logic [DIV_W-1:0] den;
  logic signed [DIV_W:0] t2;
  logic [DIV_W-1:0] k_ext;
  logic [DIV_W-1:0] q_ext;
  logic [DIV_W-1:0] nb0;
  logic [DIV_W-1:0] t2_mag;
  logic [KK_W-1:0]  kk_dist;
  logic [KK_W+19:0] kk_sum;
  logic [DIV_W:0]   t2_abs;

  // coefficients in sign and magnitude
  logic [CW-1:0] a1_mag, a2_mag, b0_mag, b1_mag, b2_mag, b0q, b0_dbl;
  logic          a1_neg, a2_neg, b0_neg, b1_neg, b2_neg;

  // history and sample path
  logic signed [HIST_W-1:0] h0, h1, w;
  logic [HIST_W-1:0]        h0_mag, h1_mag, w_mag;
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [ACC_W-1:0]  acc_w, acc_y;
  logic signed [HIST_W-1:0] w_sat;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                     w_ovf, y_ovf;

  // multiplier pipeline
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;
  logic              issue, issue_w, issue_neg;
  logic              p_valid, p_dest_w, p_neg;
  logic              t_valid, t_dest_w;
  logic signed [TERM_W-1:0] term;
  logic [PROD_W-1:0] rsum;
  logic [TERM_W-2:0] rmag;

  // output register
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_data;

  // divider
  div_req_t        div_req;
  div_stat_t       div_stat;
  logic [CW-1:0]   div_quot;

  assign din.ready       = (state == ST_IDLE) && !dirty;
  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

  assign k_ext   = DIV_W'({k_tan, 12'b0});
  assign q_ext   = DIV_W'({q_factor, 20'b0});
  assign kk_sum  = prod[KK_W+19:0] + (KK_W+20)'(1 << 19);
  assign kk_dist = (kk < KK_ONE) ? KK_ONE - kk : kk - KK_ONE;
  assign t2_abs  = t2[DIV_W] ? -t2 : t2;
  assign t2_mag  = t2_abs[DIV_W-1:0];
  assign b0_dbl  = b0q[CW-1] ? CMAX : {b0q[CW-2:0], 1'b0};

  // numerator of b0 by mode
  always_comb begin
    case (filter_mode)
      MODE_HP: nb0 = q_ext;
      MODE_BP: nb0 = k_ext;
      MODE_BR: nb0 = q_ext + kkq;
      default: nb0 = kkq;
    endcase
  end

  // divider requests: a1, then a2, then b0
  always_comb begin
    div_req.den   = den;
    div_req.start = (state == ST_D_DA1) ||
                    (div_stat.done && (state == ST_D_WA1 || state == ST_D_WA2));
    unique case (state)
      ST_D_WA1: div_req.num = t2_mag;
      ST_D_WA2: div_req.num = nb0;
      default:  div_req.num = {a1_half[DIV_W-2:0], 1'b0};
    endcase
  end

  bq_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat),
    .quot (div_quot)
  );

  // multiplier operand selection
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    issue     = 1'b0;
    issue_w   = 1'b0;
    issue_neg = 1'b0;
    unique case (state)
      ST_D_KK: begin
        mul_a = MA_W'(k_tan);
        mul_b = MB_W'(k_tan);
      end
      ST_D_KKQ: begin
        mul_a = MA_W'(kk);
        mul_b = MB_W'(q_factor);
      end
      ST_D_A1M: begin
        mul_a = MA_W'(kk_dist);
        mul_b = MB_W'(q_factor);
      end
      ST_S_M1: begin
        mul_a     = MA_W'(a1_mag);
        mul_b     = h0_mag;
        issue     = 1'b1;
        issue_w   = 1'b1;
        issue_neg = !(a1_neg ^ h0[HIST_W-1]);
      end
      ST_S_M2: begin
        mul_a     = MA_W'(a2_mag);
        mul_b     = h1_mag;
        issue     = 1'b1;
        issue_w   = 1'b1;
        issue_neg = !(a2_neg ^ h1[HIST_W-1]);
      end
      ST_S_M3: begin
        mul_a     = MA_W'(b1_mag);
        mul_b     = h0_mag;
        issue     = 1'b1;
        issue_neg = b1_neg ^ h0[HIST_W-1];
      end
      ST_S_M4: begin
        mul_a     = MA_W'(b2_mag);
        mul_b     = h1_mag;
        issue     = 1'b1;
        issue_neg = b2_neg ^ h1[HIST_W-1];
      end
      ST_S_M5: begin
        mul_a     = MA_W'(b0_mag);
        mul_b     = w_mag;
        issue     = 1'b1;
        issue_neg = b0_neg ^ w[HIST_W-1];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  bq_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // round half away from zero on the magnitude
  assign rsum = prod + (PROD_W'(1) << (COEF_FRAC_BITS - 1));
  assign rmag = rsum[COEF_FRAC_BITS+TERM_W-2:COEF_FRAC_BITS];

  // saturation of w and y
  assign w_ovf = !((&acc_w[ACC_W-1:HIST_W-1]) || !(|acc_w[ACC_W-1:HIST_W-1]));
  assign w_sat = w_ovf ? {acc_w[ACC_W-1], {(HIST_W-1){!acc_w[ACC_W-1]}}}
                       : acc_w[HIST_W-1:0];
  assign y_ovf = !((&acc_y[ACC_W-1:SAMPLE_WIDTH-1]) ||
                   !(|acc_y[ACC_W-1:SAMPLE_WIDTH-1]));
  assign y_sat = y_ovf ? {acc_y[ACC_W-1], {(SAMPLE_WIDTH-1){!acc_y[ACC_W-1]}}}
                       : acc_y[SAMPLE_WIDTH-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_tan       <= K_RESET;
      q_factor    <= Q_RESET;
      filter_mode <= MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_K_TAN:       k_tan       <= cfg_wdata[K_W-1:0];
        REG_Q_FACTOR:    q_factor    <= cfg_wdata[Q_W-1:0];
        REG_FILTER_MODE: filter_mode <= cfg_wdata[MODE_W-1:0];
        default:         k_tan       <= k_tan;
      endcase
    end
  end

  // product, rounding and accumulation pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      t_valid <= 1'b0;
    end else begin
      p_valid <= issue;
      t_valid <= p_valid;
    end
    p_dest_w <= issue_w;
    p_neg    <= issue_neg;
    t_dest_w <= p_dest_w;
    term     <= p_neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    if (state == ST_S_M1) begin
      acc_w <= {{(ACC_W-SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg};
      acc_y <= '0;
    end else if (t_valid) begin
      if (t_dest_w) begin
        acc_w <= acc_w + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
      end else begin
        acc_y <= acc_y + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
      end
    end
  end

  // sequencer: derivation, filtering, clearing, output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dirty     <= 1'b1;
      out_valid <= 1'b0;
      h0        <= '0;
      h1        <= '0;
      h0_mag    <= '0;
      h1_mag    <= '0;
    end else begin
      // result taken; the last steps reload the register themselves
      if (out_valid && dout.ready && state != ST_S_Y && state != ST_S_CLR) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        dirty <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (dirty) begin
            if (!cfg_we) begin
              dirty <= 1'b0;
            end
            state <= ST_D_KK;
          end else if (din.valid) begin
            x_reg <= din.sample_in;
            state <= din.op ? ST_S_CLR : ST_S_M1;
          end
        end
        ST_D_KK:  state <= ST_D_KKR;
        ST_D_KKR: begin
          kk    <= kk_sum[KK_W+19:20];
          state <= ST_D_KKQ;
        end
        ST_D_KKQ: state <= ST_D_A1M;
        ST_D_A1M: begin
          kkq    <= prod[DIV_W-1:0];
          a1_neg <= kk < KK_ONE;
          state  <= ST_D_SUM;
        end
        ST_D_SUM: begin
          a1_half <= prod[DIV_W-1:0];
          den     <= kkq + k_ext + q_ext;
          t2      <= $signed({1'b0, kkq}) + $signed({1'b0, q_ext})
                     - $signed({1'b0, k_ext});
          state   <= ST_D_DA1;
        end
        ST_D_DA1: state <= ST_D_WA1;
        ST_D_WA1: begin
          if (div_stat.done) begin
            a1_mag <= div_quot;
            a2_neg <= t2[DIV_W];
            state  <= ST_D_WA2;
          end
        end
        ST_D_WA2: begin
          if (div_stat.done) begin
            a2_mag <= div_quot;
            state  <= ST_D_WB0;
          end
        end
        ST_D_WB0: begin
          if (div_stat.done) begin
            b0q   <= div_quot;
            state <= ST_D_FIN;
          end
        end
        ST_D_FIN: begin
          case (filter_mode)
            MODE_HP: begin
              b0_mag <= b0q;    b0_neg <= 1'b0;
              b1_mag <= b0_dbl; b1_neg <= 1'b1;
              b2_mag <= b0q;    b2_neg <= 1'b0;
            end
            MODE_BP: begin
              b0_mag <= b0q;    b0_neg <= 1'b0;
              b1_mag <= '0;     b1_neg <= 1'b0;
              b2_mag <= b0q;    b2_neg <= 1'b1;
            end
            MODE_BR: begin
              b0_mag <= b0q;    b0_neg <= 1'b0;
              b1_mag <= a1_mag; b1_neg <= a1_neg;
              b2_mag <= b0q;    b2_neg <= 1'b0;
            end
            MODE_AP: begin
              b0_mag <= a2_mag;   b0_neg <= a2_neg;
              b1_mag <= a1_mag;   b1_neg <= a1_neg;
              b2_mag <= COEF_ONE; b2_neg <= 1'b0;
            end
            default: begin
              b0_mag <= b0q;    b0_neg <= 1'b0;
              b1_mag <= b0_dbl; b1_neg <= 1'b0;
              b2_mag <= b0q;    b2_neg <= 1'b0;
            end
          endcase
          state <= ST_IDLE;
        end
        ST_S_M1: state <= ST_S_M2;
        ST_S_M2: state <= ST_S_M3;
        ST_S_M3: state <= ST_S_M4;
        ST_S_M4: state <= ST_S_W;
        ST_S_W: begin
          w     <= w_sat;
          w_mag <= w_sat[HIST_W-1] ? HIST_W'(-w_sat) : HIST_W'(w_sat);
          state <= ST_S_M5;
        end
        ST_S_M5: state <= ST_S_D1;
        ST_S_D1: state <= ST_S_D2;
        ST_S_D2: state <= ST_S_Y;
        ST_S_Y: begin
          if (!out_valid || dout.ready) begin
            out_data  <= y_sat;
            out_valid <= 1'b1;
            h1        <= h0;
            h1_mag    <= h0_mag;
            h0        <= w;
            h0_mag    <= w_mag;
            state     <= ST_IDLE;
          end
        end
        ST_S_CLR: begin
          if (!out_valid || dout.ready) begin
            out_data  <= '0;
            out_valid <= 1'b1;
            h0        <= '0;
            h1        <= '0;
            h0_mag    <= '0;
            h1_mag    <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // stored magnitudes follow the history words
  a_h0_mag: assert property (@(posedge clk) disable iff (rst)
    h0_mag == (h0[HIST_W-1] ? HIST_W'(-h0) : HIST_W'(h0)))
    else $error("h0 magnitude out of step with h0");

  a_h1_mag: assert property (@(posedge clk) disable iff (rst)
    h1_mag == (h1[HIST_W-1] ? HIST_W'(-h1) : HIST_W'(h1)))
    else $error("h1 magnitude out of step with h1");

  // a clear request goes straight to the clear step
  a_clear: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready && din.op |=> state == ST_S_CLR)
    else $error("clear request not handled");

  // divider only runs while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_D_WA1 || state == ST_D_WA2 ||
                       state == ST_D_WB0))
    else $error("divider busy outside derivation");

  // rounded terms only arrive during the filter steps
  a_term: assert property (@(posedge clk) disable iff (rst)
    t_valid |-> (state == ST_S_M3 || state == ST_S_M4 || state == ST_S_W ||
                 state == ST_S_M5 || state == ST_S_D2))
    else $error("product term outside filter steps");

endmodule

// ===== tb/biquad_direct_form_two_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_direct_form_two_filter_test: self-checking bench for the biquad
// drives filter and clear requests with random gaps and output stalls, and
// checks every sample against a bit-exact model of the filter, across many
// cutoff, quality and mode settings including the degenerate ones
// ----------------------------------------------------------------------------
module biquad_direct_form_two_filter_test;
  import bq_pkg::*;

  localparam int SW   = 24;
  localparam int FRAC = 28;
  localparam longint CMAX   = (longint'(1) <<< (FRAC + 3)) - 1;
  localparam longint H_MAX  = 64'sd2147483647;
  localparam longint H_MIN  = -64'sd2147483648;
  localparam longint S_MAX  = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint S_MIN  = -(longint'(1) <<< (SW - 1));
  localparam logic signed [SW-1:0] X_MAX = SW'(S_MAX);
  localparam logic signed [SW-1:0] X_MIN = SW'(S_MIN);
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 14;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    longint b0, b1, b2, a1, a2;
  } coef_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bq_in_if  #(.SAMPLE_WIDTH(SW)) din_if ();
  bq_out_if #(.SAMPLE_WIDTH(SW)) dout_if ();

  biquad_direct_form_two_filter #(
    .SAMPLE_WIDTH(SW),
    .COEF_FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .din(din_if.sink),
    .dout(dout_if.source)
  );

  // model copy of registers and history
  longint unsigned k_cur, q_cur;
  logic [MODE_W-1:0] mode_cur;
  longint hist0, hist1;

  logic signed [SW-1:0] expected_samples[$];
  int errors = 0;
  int sent = 0;
  int clears = 0;
  int checked = 0;
  int settings = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  always #10 clk = ~clk;

  initial begin
    din_if.valid <= 1'b0;
    din_if.op <= OP_FILTER;
    din_if.sample_in <= '0;
    dout_if.ready <= 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_samples.size());
      $display("FAIL biquad_direct_form_two_filter");
      $finish;
    end
  end

  // magnitude long division, clamped
  function automatic longint coef_div(longint num, longint unsigned den);
    longint unsigned n, ip, r, qt;
    if (den == 0) return 0;
    n = (num < 0) ? longint'(-num) : longint'(num);
    ip = n / den;
    if (ip >= 8) begin
      qt = CMAX;
    end else begin
      r = n % den;
      qt = ip;
      for (int i = 0; i < FRAC; i++) begin
        r = r << 1;
        qt = qt << 1;
        if (r >= den) begin
          r = r - den;
          qt = qt | 1;
        end
      end
      if (qt > CMAX) qt = CMAX;
    end
    return (num < 0) ? -longint'(qt) : longint'(qt);
  endfunction

  function automatic longint coef_clamp(longint v);
    if (v > CMAX) return CMAX;
    if (v < -CMAX) return -CMAX;
    return v;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic coef_set_t derive_coefs();
    coef_set_t c;
    longint unsigned kk, kkq, kt, qt, den;
    longint na1, na2;
    kk = (k_cur * k_cur + (longint'(1) << 19)) >> 20;
    kkq = kk * q_cur;
    kt = k_cur << 12;
    qt = q_cur << 20;
    den = kkq + kt + qt;
    na1 = 2 * longint'(q_cur) * (longint'(kk) - (longint'(1) << 20));
    na2 = longint'(kkq) - longint'(kt) + longint'(qt);
    c.a1 = coef_div(na1, den);
    c.a2 = coef_div(na2, den);
    case (mode_cur)
      MODE_HP: begin
        c.b0 = coef_div(longint'(qt), den);
        c.b1 = coef_clamp(-2 * c.b0);
        c.b2 = c.b0;
      end
      MODE_BP: begin
        c.b0 = coef_div(longint'(kt), den);
        c.b1 = 0;
        c.b2 = -c.b0;
      end
      MODE_BR: begin
        c.b0 = coef_div(longint'(qt + kkq), den);
        c.b1 = c.a1;
        c.b2 = c.b0;
      end
      MODE_AP: begin
        c.b0 = c.a2;
        c.b1 = c.a1;
        c.b2 = longint'(1) << FRAC;
      end
      default: begin
        c.b0 = coef_div(longint'(kkq), den);
        c.b1 = coef_clamp(2 * c.b0);
        c.b2 = c.b0;
      end
    endcase
    return c;
  endfunction

  // rounded coefficient product, half away from zero
  function automatic longint coef_mul(longint c, longint v);
    longint unsigned cm, vm, m;
    bit neg;
    neg = (c < 0) != (v < 0);
    cm = (c < 0) ? longint'(-c) : longint'(c);
    vm = (v < 0) ? longint'(-v) : longint'(v);
    m = (cm * vm + (longint'(1) << (FRAC - 1))) >> FRAC;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [SW-1:0] filter_sample(logic op,
                                                         logic signed [SW-1:0] x);
    coef_set_t c;
    longint w, y;
    if (op == OP_CLEAR) begin
      hist0 = 0;
      hist1 = 0;
      return '0;
    end
    c = derive_coefs();
    w = sat(longint'(x) - coef_mul(c.a1, hist0) - coef_mul(c.a2, hist1), H_MIN, H_MAX);
    y = coef_mul(c.b0, w) + coef_mul(c.b1, hist0) + coef_mul(c.b2, hist1);
    hist1 = hist0;
    hist0 = w;
    return SW'(sat(y, S_MIN, S_MAX));
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // send one request, predict on acceptance
  task automatic send_request(logic op, logic signed [SW-1:0] x);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.op <= op;
    din_if.sample_in <= x;
    do @(posedge clk); while (!din_if.ready);
    expected_samples.push_back(filter_sample(op, x));
    sent++;
    if (op == OP_CLEAR) clears++;
  endtask

  // result side with random stalls
  initial begin
    int stall;
    logic signed [SW-1:0] exp_s;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        dout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      do @(posedge clk); while (!dout_if.valid);
      if (expected_samples.size() == 0) begin
        report($sformatf("unexpected result %0d", dout_if.sample_out));
      end else begin
        exp_s = expected_samples.pop_front();
        checked++;
        if (dout_if.sample_out !== exp_s)
          report($sformatf("sample_out %0d, expected %0d (k %0d q %0d mode %0d)",
                           dout_if.sample_out, exp_s, k_cur, q_cur, mode_cur));
      end
    end
  end

  task automatic drain();
    din_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // idle write of all three registers
  task automatic set_filter(longint unsigned k, longint unsigned q,
                            logic [MODE_W-1:0] mode);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_K_TAN;
    cfg_wdata <= CFG_W'(k);
    @(posedge clk);
    cfg_index <= REG_Q_FACTOR;
    cfg_wdata <= CFG_W'(q);
    @(posedge clk);
    cfg_index <= REG_FILTER_MODE;
    cfg_wdata <= CFG_W'(mode);
    @(posedge clk);
    cfg_we <= 1'b0;
    k_cur = k & 24'hFFFFFF;
    q_cur = q & 16'hFFFF;
    mode_cur = mode;
    settings++;
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return X_MAX;
      1: return X_MIN;
      2: return SW'(int'($urandom_range(0, 64)) - 32);
      default: return SW'($urandom);
    endcase
  endfunction

  // extremes under the reset settings
  task automatic test_reset_settings();
    send_request(OP_FILTER, X_MAX);
    send_request(OP_FILTER, X_MAX);
    send_request(OP_FILTER, X_MIN);
    send_request(OP_FILTER, SW'(-1));
    send_request(OP_CLEAR, X_MAX);
    send_request(OP_FILTER, SW'(1));
  endtask

  // each mode, spare mode included
  task automatic test_modes();
    logic [MODE_W-1:0] m [6] = '{MODE_LP, MODE_HP, MODE_BP, MODE_BR, MODE_AP,
                                 MODE_SPARE_LO};
    foreach (m[i]) begin
      set_filter(K_RESET / 3, Q_RESET, m[i]);
      send_request(OP_FILTER, X_MAX);
      send_request(OP_FILTER, X_MIN);
    end
  endtask

  // zero divisor, q of zero and largest k and q
  task automatic test_degenerate();
    set_filter(0, 0, MODE_AP);
    send_request(OP_FILTER, X_MAX);
    send_request(OP_FILTER, X_MIN);
    set_filter(0, 0, MODE_LP);
    send_request(OP_FILTER, X_MAX);
    set_filter(24'hFFFFFF, 0, MODE_BR);
    send_request(OP_FILTER, X_MIN);
    set_filter(24'hFFFFFF, 16'hFFFF, MODE_SPARE_HI);
    send_request(OP_FILTER, X_MAX);
    send_request(OP_FILTER, X_MIN);
  endtask

  // random settings, random samples, occasional clears
  task automatic test_random_phases();
    longint unsigned k, q;
    logic [MODE_W-1:0] mode;
    for (int p = 0; p < 15; p++) begin
      case ($urandom_range(0, 4))
        0: k = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
        1: k = $urandom_range(0, 24'hFFFFFF);
        default: k = $urandom_range(1, 24'h200000);
      endcase
      case ($urandom_range(0, 4))
        0: q = $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(0, 1);
        1: q = $urandom_range(0, 16'hFFFF);
        default: q = $urandom_range(1000, 40000);
      endcase
      mode = (p < 8) ? MODE_W'(p) : MODE_W'($urandom_range(0, MODE_SPARE_HI));
      set_filter(k, q, mode);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 60; i++)
        send_request(($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_FILTER,
                     pick_sample());
      no_idle = 1'b0;
    end
  endtask

  initial begin
    k_cur = K_RESET;
    q_cur = Q_RESET;
    mode_cur = MODE_RESET;
    hist0 = 0;
    hist1 = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_modes();
    test_degenerate();
    test_random_phases();
    drain();
    $display("covered %0d requests (%0d clears) over %0d filter settings", sent,
             clears, settings);
    $display("checked %0d results, %0d mismatches", checked, errors);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("PASS biquad_direct_form_two_filter");
    end else begin
      $display("FAIL biquad_direct_form_two_filter");
    end
    $finish;
  end

endmodule
